// ----- src/lcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

  localparam int LANES  = 8;
  localparam int COEF_W = 13;
  localparam int CODE_W = 11;
  localparam int PACK_W = 88;
  localparam int LOW_W  = 64;
  localparam int HIGH_W = 24;

  localparam logic [1:0] MODE_D4  = 2'd0;
  localparam logic [1:0] MODE_D5  = 2'd1;
  localparam logic [1:0] MODE_D10 = 2'd2;
  localparam logic [1:0] MODE_D11 = 2'd3;

  localparam logic REG_BITS_MODE = 1'b0;
  localparam logic REG_COMPARE   = 1'b1;

  localparam logic [15:0] KQ = 16'd3329;

  typedef struct packed {
    logic [1:0] bits_mode;
    logic       compare_enable;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/lattice_coef_compress_pack_top.sv -----
// Stage 1 registers lane codes and ref bits, the output stage the packed word.
// Throughput: one beat per cycle unless m_tready stalls; eight lanes each run
// one constant multiply per cycle, packing and compare sit in the output stage.
// Reset (rst, synchronous): both stages empty, config registers and the
// mismatch flag cleared.
`timescale 1ns / 1ps
`default_nettype none

module lattice_coef_compress_pack_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // coef_0..coef_7 (13b each), ref_low (64b), ref_high (24b)
  input  wire logic [191:0] s_tdata,
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // packed_low (64b), packed_high (24b)
  output logic      [87:0]  m_tdata,
  // mismatch
  output logic              m_tuser,
  output logic              m_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [1:0]   cfg_data
);

  localparam int REF_LSB = lcc_pkg::LANES * lcc_pkg::COEF_W;

  lcc_pkg::cfg_t cfg;

  logic                       s1_valid;
  logic [lcc_pkg::PACK_W-1:0] s1_ref;
  logic                       s1_last;
  logic                       s1_load;
  logic                       s2_load;
  logic                       mismatch_acc;
  logic                       mismatch_now;
  logic                       diff;
  logic [lcc_pkg::PACK_W-1:0] packed_bits;
  logic [lcc_pkg::CODE_W-1:0] codes [lcc_pkg::LANES];

  assign s2_load  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s2_load;
  assign s1_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcc_pkg::REG_BITS_MODE: cfg.bits_mode      <= cfg_data;
        lcc_pkg::REG_COMPARE:   cfg.compare_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  for (genvar j = 0; j < lcc_pkg::LANES; j++) begin : g_lane
    lcc_lane u_lane (
      .clk       (clk),
      .en        (s1_load),
      .bits_mode (cfg.bits_mode),
      .coef      (s_tdata[j*lcc_pkg::COEF_W +: lcc_pkg::COEF_W]),
      .code      (codes[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ref  <= s_tdata[REF_LSB +: lcc_pkg::PACK_W];
      s1_last <= s_tlast;
    end
  end

  lcc_merge u_merge (
    .codes       (codes),
    .bits_mode   (cfg.bits_mode),
    .ref_bits    (s1_ref),
    .packed_bits (packed_bits),
    .diff        (diff)
  );

  assign mismatch_now = mismatch_acc | (cfg.compare_enable & diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_acc <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (s2_load) begin
        mismatch_acc <= s1_last ? 1'b0 : mismatch_now;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      m_tdata <= packed_bits;
      m_tuser <= mismatch_now;
      m_tlast <= s1_last;
    end
  end

`ifndef SYNTHESIS
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    s2_load && s1_last |=> !mismatch_acc)
    else $error("mismatch flag not cleared after last group");

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !m_tvalid |=> m_tvalid)
    else $error("stage 1 beat did not reach output");

  a_d4_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cfg.bits_mode == lcc_pkg::MODE_D4 |-> m_tdata[87:32] == '0)
    else $error("bits above 32 set in 4-bit mode");
`endif

endmodule

`default_nettype wire

// ----- src/lcc_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcc_lane (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [1:0]                  bits_mode,
  input  wire logic [lcc_pkg::COEF_W-1:0]  coef,
  output logic      [lcc_pkg::CODE_W-1:0]  code
);

  logic [15:0] u;
  logic [26:0] a;
  logic [20:0] k;
  logic [47:0] p;
  logic [lcc_pkg::CODE_W-1:0] code_next;

  // negative: add q, wrap to 16 bits
  always_comb begin
    if (coef[lcc_pkg::COEF_W-1]) begin
      u = 16'(coef) + 16'hE000 + lcc_pkg::KQ;
    end else begin
      u = 16'(coef);
    end
  end

  always_comb begin
    unique case (bits_mode)
      lcc_pkg::MODE_D4: begin
        a = 27'({u, 4'b0}) + 27'd1665;
        k = 21'd80635;
      end
      lcc_pkg::MODE_D5: begin
        a = 27'({u, 5'b0}) + 27'd1664;
        k = 21'd40318;
      end
      lcc_pkg::MODE_D10: begin
        a = 27'({u, 10'b0}) + 27'd1665;
        k = 21'd1290167;
      end
      default: begin
        a = {u, 11'b0} + 27'd1664;
        k = 21'd645084;
      end
    endcase
  end

  assign p = 48'(a) * 48'(k);

  always_comb begin
    unique case (bits_mode)
      lcc_pkg::MODE_D4:  code_next = 11'(p[31:28]);
      lcc_pkg::MODE_D5:  code_next = 11'(p[31:27]);
      lcc_pkg::MODE_D10: code_next = 11'(p[41:32]);
      default:           code_next = p[41:31];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code <= code_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/lcc_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcc_merge (
  input  wire logic [lcc_pkg::CODE_W-1:0] codes [lcc_pkg::LANES],
  input  wire logic [1:0]                 bits_mode,
  input  wire logic [lcc_pkg::PACK_W-1:0] ref_bits,
  output logic      [lcc_pkg::PACK_W-1:0] packed_bits,
  output logic                            diff
);

  logic [lcc_pkg::PACK_W-1:0] mask;

  always_comb begin
    packed_bits = '0;
    mask        = '0;
    unique case (bits_mode)
      lcc_pkg::MODE_D4: begin
        for (int j = 0; j < lcc_pkg::LANES; j++) begin
          packed_bits[j*4 +: 4] = codes[j][3:0];
          mask[j*4 +: 4]        = '1;
        end
      end
      lcc_pkg::MODE_D5: begin
        for (int j = 0; j < lcc_pkg::LANES; j++) begin
          packed_bits[j*5 +: 5] = codes[j][4:0];
          mask[j*5 +: 5]        = '1;
        end
      end
      lcc_pkg::MODE_D10: begin
        for (int j = 0; j < lcc_pkg::LANES; j++) begin
          packed_bits[j*10 +: 10] = codes[j][9:0];
          mask[j*10 +: 10]        = '1;
        end
      end
      default: begin
        for (int j = 0; j < lcc_pkg::LANES; j++) begin
          packed_bits[j*11 +: 11] = codes[j];
          mask[j*11 +: 11]        = '1;
        end
      end
    endcase
  end

  assign diff = |((packed_bits ^ ref_bits) & mask);

endmodule

`default_nettype wire

// ----- test/lattice_coef_compress_pack_top_tb.sv -----
`timescale 1ns / 1ps

module lattice_coef_compress_pack_top_tb;

  localparam int LIMIT        = 2000;
  localparam int PHASES       = 12;
  localparam int PHASE_GROUPS = 111;

  typedef struct packed {
    logic [lcc_pkg::HIGH_W-1:0]                    ref_high;
    logic [lcc_pkg::LOW_W-1:0]                     ref_low;
    logic [lcc_pkg::LANES-1:0][lcc_pkg::COEF_W-1:0] coef;
    logic                                          last;
  } group_t;

  typedef struct packed {
    logic [lcc_pkg::PACK_W-1:0] bits;
    logic                       flag;
    logic                       last;
  } packed_word_t;

  class pack_scoreboard;
    logic [1:0]   mode;
    logic         cmp;
    logic         acc;
    packed_word_t expected_words[$];
    int           groups_in, seen_words, bad_words, stray_words;
    int           flagged_words, poly_ends;

    function new();
      mode = lcc_pkg::MODE_D4;
      cmp  = 1'b0;
      acc  = 1'b0;
    endfunction

    function int width();
      case (mode)
        lcc_pkg::MODE_D4:  return 4;
        lcc_pkg::MODE_D5:  return 5;
        lcc_pkg::MODE_D10: return 10;
        default:           return 11;
      endcase
    endfunction

    function logic [lcc_pkg::PACK_W-1:0] used_mask();
      return (lcc_pkg::PACK_W'(1) << (lcc_pkg::LANES * width())) - 1;
    endfunction

    // negative inputs get q added, then wrap to 16 bits
    function logic [lcc_pkg::CODE_W-1:0] squeeze(logic [lcc_pkg::COEF_W-1:0] c);
      logic [15:0] u;
      logic [63:0] t;
      u = c[lcc_pkg::COEF_W-1] ? 16'(c) + 16'hE000 + lcc_pkg::KQ : 16'(c);
      case (mode)
        lcc_pkg::MODE_D4: begin
          t = ((64'(u) << 4) + 64'd1665) * 64'd80635;
          return lcc_pkg::CODE_W'((t >> 28) & 64'hf);
        end
        lcc_pkg::MODE_D5: begin
          t = ((64'(u) << 5) + 64'd1664) * 64'd40318;
          return lcc_pkg::CODE_W'((t >> 27) & 64'h1f);
        end
        lcc_pkg::MODE_D10: begin
          t = ((64'(u) << 10) + 64'd1665) * 64'd1290167;
          return lcc_pkg::CODE_W'((t >> 32) & 64'h3ff);
        end
        default: begin
          t = ((64'(u) << 11) + 64'd1664) * 64'd645084;
          return lcc_pkg::CODE_W'((t >> 31) & 64'h7ff);
        end
      endcase
    endfunction

    function logic [lcc_pkg::PACK_W-1:0] pack(
      logic [lcc_pkg::LANES-1:0][lcc_pkg::COEF_W-1:0] coef);
      logic [lcc_pkg::PACK_W-1:0] p;
      int                         d;
      d = width();
      p = '0;
      for (int j = 0; j < lcc_pkg::LANES; j++)
        p |= lcc_pkg::PACK_W'(squeeze(coef[j])) << (j * d);
      return p;
    endfunction

    function void note_group(group_t g);
      packed_word_t               w;
      logic [lcc_pkg::PACK_W-1:0] refs;
      w.bits = pack(g.coef);
      refs   = {g.ref_high, g.ref_low};
      if (cmp && (((w.bits ^ refs) & used_mask()) != '0)) acc = 1'b1;
      w.flag = acc;
      w.last = g.last;
      if (g.last) acc = 1'b0;
      expected_words.push_back(w);
      groups_in++;
    endfunction

    function void check_word(logic [lcc_pkg::PACK_W-1:0] bits, logic flag, logic last);
      packed_word_t w;
      seen_words++;
      if (expected_words.size() == 0) begin
        stray_words++;
        if (bad_words + stray_words <= 10)
          $display("unexpected beat: low %h high %h mismatch %b end %b",
                   bits[lcc_pkg::LOW_W-1:0], bits[lcc_pkg::PACK_W-1:lcc_pkg::LOW_W],
                   flag, last);
        return;
      end
      w = expected_words.pop_front();
      if (bits[lcc_pkg::LOW_W-1:0] !== w.bits[lcc_pkg::LOW_W-1:0] ||
          bits[lcc_pkg::PACK_W-1:lcc_pkg::LOW_W] !==
          w.bits[lcc_pkg::PACK_W-1:lcc_pkg::LOW_W] ||
          flag !== w.flag || last !== w.last) begin
        bad_words++;
        if (bad_words + stray_words <= 10)
          $display("bad beat %0d: exp low %h high %h mis %b end %b,",
                   seen_words, w.bits[lcc_pkg::LOW_W-1:0],
                   w.bits[lcc_pkg::PACK_W-1:lcc_pkg::LOW_W], w.flag, w.last,
                   " got low %h high %h mis %b end %b",
                   bits[lcc_pkg::LOW_W-1:0], bits[lcc_pkg::PACK_W-1:lcc_pkg::LOW_W],
                   flag, last);
      end
      if (w.flag) flagged_words++;
      if (w.last) poly_ends++;
    endfunction
  endclass

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic [191:0] s_tdata   = '0;
  logic         s_tlast   = 1'b0;
  logic         m_tready  = 1'b0;
  logic         cfg_we    = 1'b0;
  logic         cfg_index = 1'b0;
  logic [1:0]   cfg_data  = 2'b00;
  logic         s_tready;
  logic         m_tvalid;
  logic [87:0]  m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  pack_scoreboard sb;
  bit             steady;
  int             settings_used;
  int             quiet_cycles = 0;
  int             corner_vals[13] = '{0, 3328, -3328, 1, -1, 1664, 1665, -1664, -1665,
                                      4095, -4096, 832, 2496};

  lattice_coef_compress_pack_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LIMIT) begin
      $display("FAIL lattice_coef_compress_pack_top");
      $finish;
    end
  end

  function automatic logic [lcc_pkg::COEF_W-1:0] rand_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return lcc_pkg::COEF_W'($urandom_range(0, 6656) - 3328);
    if (r < 90) return lcc_pkg::COEF_W'(corner_vals[$urandom_range(0, 12)]);
    return lcc_pkg::COEF_W'($urandom);
  endfunction

  function automatic logic [lcc_pkg::PACK_W-1:0] rand_bits();
    return lcc_pkg::PACK_W'({$urandom, $urandom, $urandom});
  endfunction

  function automatic group_t corner_group(int k, logic last);
    group_t g;
    for (int j = 0; j < lcc_pkg::LANES; j++)
      g.coef[j] = lcc_pkg::COEF_W'(corner_vals[(k * 3 + j) % 13]);
    {g.ref_high, g.ref_low} = rand_bits();
    g.last = last;
    return g;
  endfunction

  function automatic logic [lcc_pkg::PACK_W-1:0] one_used_bit();
    return lcc_pkg::PACK_W'(1) << $urandom_range(0, lcc_pkg::LANES * sb.width() - 1);
  endfunction

  task automatic send_group(group_t g);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {g.ref_high, g.ref_low, g.coef};
    s_tlast  <= g.last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_group(g);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0);
  endtask

  task automatic set_config(logic [1:0] mode, logic cmp);
    drain();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lcc_pkg::REG_BITS_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_index <= lcc_pkg::REG_COMPARE;
    cfg_data  <= {1'b0, cmp};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.mode = mode;
    sb.cmp  = cmp;
    settings_used++;
  endtask

  // output side: random stalls per beat, none in steady phases
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_word(m_tdata, m_tuser, m_tlast);
    end
  end

  initial begin
    group_t                     g;
    logic [lcc_pkg::PACK_W-1:0] exact;
    logic [lcc_pkg::PACK_W-1:0] refs;
    logic [1:0]                 mode;
    logic                       cmp;
    int                         left;
    int                         r;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 4 bits, compare off
    for (int k = 0; k < 8; k++) send_group(corner_group(k, k == 7));

    for (int m = 0; m < 4; m++) begin
      set_config(2'(m), 1'b1);
      // match with noise in unused ref bits
      g     = corner_group(8 + m * 4, 1'b0);
      exact = sb.pack(g.coef);
      {g.ref_high, g.ref_low} = exact | (rand_bits() & ~sb.used_mask());
      send_group(g);
      // match, end of poly
      g = corner_group(9 + m * 4, 1'b1);
      {g.ref_high, g.ref_low} = sb.pack(g.coef);
      send_group(g);
      // one used bit flipped
      g     = corner_group(10 + m * 4, 1'b0);
      exact = sb.pack(g.coef);
      {g.ref_high, g.ref_low} = exact ^ one_used_bit();
      send_group(g);
      // flag stays set through the end, then clears
      g = corner_group(11 + m * 4, 1'b1);
      {g.ref_high, g.ref_low} = sb.pack(g.coef);
      send_group(g);
    end

    left = 0;
    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) begin
        mode = 2'(p % 4);
        cmp  = 1'((p / 4) % 2);
      end else begin
        mode = 2'($urandom_range(0, 3));
        cmp  = 1'($urandom_range(0, 1));
      end
      set_config(mode, cmp);
      steady = (p % 5 == 2);
      for (int i = 0; i < PHASE_GROUPS; i++) begin
        if (i == PHASE_GROUPS / 2) drain();
        if (left == 0) left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 32;
        for (int j = 0; j < lcc_pkg::LANES; j++) g.coef[j] = rand_coef();
        exact = sb.pack(g.coef);
        refs  = rand_bits();
        r     = $urandom_range(0, 99);
        if (cmp && r < 70) refs = exact | (refs & ~sb.used_mask());
        else if (cmp && r < 85) refs = exact ^ one_used_bit();
        {g.ref_high, g.ref_low} = refs;
        g.last = (left == 1);
        left--;
        send_group(g);
      end
    end
    steady = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d coefficient groups, checked %0d beats over %0d register settings",
             sb.groups_in, sb.seen_words, settings_used);
    $display("(all widths, compare on/off): %0d polynomial ends, %0d flagged beats,",
             sb.poly_ends, sb.flagged_words,
             " %0d bad, %0d unexpected", sb.bad_words, sb.stray_words);
    if (sb.bad_words == 0 && sb.stray_words == 0 && sb.expected_words.size() == 0) begin
      $display("PASS lattice_coef_compress_pack_top");
    end else begin
      $display("FAIL lattice_coef_compress_pack_top");
    end
    $finish;
  end

endmodule
